FILE: rtl/core/priority_task_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
// Needs a clk and a rst signal in the scope where a macro is used.
`ifndef PRIORITY_TASK_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PTS_ASSERT(lbl, prop, msg)
`define PTS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/pts_pkg.sv
// Shared types and constants of the priority task scheduler.
// No dependencies.
package pts_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int CPUS_DEF      = 4;
  localparam int PRIO_BITS_DEF = 8;
  localparam logic [7:0] RELOAD_RESET = 8'd10;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_BLOCKED  = 3'd4
  } slot_st_t;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_EXIT   = 3'd1,
    OP_TICK   = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_BLOCK  = 3'd4,
    OP_WAKE   = 3'd5,
    OP_MKRDY  = 3'd6,
    OP_LOAD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_NO_FREE    = 2'd1,
    RES_IDLE       = 2'd2,
    RES_NO_CURRENT = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DECIDE,
    S_DONE
  } fsm_t;

endpackage

FILE: rtl/core/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/priority_task_scheduler_core.sv
// Priority task scheduler: slot table in RAM, per-CPU current slot in flops.
// Depends on pts_pkg, pts_ram and priority_task_scheduler_core_defines.svh.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  cfg     | cfg_valid, cfg_ready, slice_reload             | in
//  in      | in_valid, in_ready, operation, cpu, slot,      | in
//          | priority_req, duration, all_cpus               |
//  out     | out_valid, out_ready, status, slot_out,        | out
//          | switched, fresh_start, load_count              |
//
// Sequence: an item runs one sweep over the slot RAM, and a second
//   sweep when a slot is dispatched or reselected; sleep or block with
//   no current slot skips both. Each sweep is a read-modify-write pass,
//   one entry per cycle.
// Reset: synchronous; per-entry valid bits make every slot read as its
//   reset value at once, so no clearing pass is needed.
// Stalls: a result waits in the output register; the next beat is taken
//   meanwhile, and its result waits for the register to drain.
`include "priority_task_scheduler_core_defines.svh"
module priority_task_scheduler_core #(
  parameter int SLOTS     = pts_pkg::SLOTS_DEF,
  parameter int CPUS      = pts_pkg::CPUS_DEF,
  parameter int PRIO_BITS = pts_pkg::PRIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  slice_reload,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [1:0]  cpu,
  input  logic [3:0]  slot,
  input  logic [7:0]  priority_req,
  input  logic [31:0] duration,
  input  logic        all_cpus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  slot_out,
  output logic        switched,
  output logic        fresh_start,
  output logic [4:0]  load_count
);
  import pts_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int RW   = $clog2(SLOTS + 1);
  localparam int CW   = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int AFW  = $clog2(CPUS + 1);
  localparam int PW   = PRIO_BITS;
  localparam logic [AFW-1:0] AFF_ANY = AFW'(CPUS);

  typedef struct packed {
    slot_st_t        st;
    logic [AFW-1:0]  af;
    logic [PW-1:0]   pr;
    logic [7:0]      sl;
    logic [31:0]     wk;
    logic            fr;
  } entry_t;

  localparam int EW = $bits(entry_t);
  localparam entry_t RESET_ENTRY = '{st: ST_FREE, af: AFF_ANY, pr: PW'(1),
                                     sl: RELOAD_RESET, wk: 32'd0, fr: 1'b0};

  // Configuration and global state
  logic [7:0]      reload;
  logic [31:0]     tick_counter;
  logic [CPUS-1:0] cur_has;
  logic [SW-1:0]   cur_slot [CPUS];
  logic [SLOTS-1:0] valid;

  // Control
  fsm_t          state, state_next;
  logic          phase;
  logic [RW-1:0] ridx;
  logic          pv;
  logic [SW-1:0] pidx;
  logic          issue;
  logic          last;

  // Latched item
  op_t           op_r;
  logic [CW-1:0] cpu_r;
  logic [3:0]    slot_r;
  logic [PW-1:0] prio_r;
  logic [31:0]   dur_r;
  logic          all_r;
  logic          had_r;
  logic [SW-1:0] prev_r;

  // Sweep accumulators
  logic          found;
  logic [SW-1:0] fidx;
  logic          best_v;
  logic [SW-1:0] best_idx;
  logic [PW-1:0] best_pr;
  logic [RW-1:0] cnt;
  logic          keep;
  logic [SW-1:0] tgt_r;
  logic          disp_r;

  // Result
  res_t          res_status;
  logic [SW-1:0] res_slot;
  logic          res_sw;
  logic          res_fresh;

  // RAM
  logic [EW-1:0] ram_rdata;
  entry_t        e_rd, e_new;
  logic          take_create, is_prev, is_tgt, slot_hit, run_new, cnt_hit, keep_hit;
  logic [7:0]    sl_dec;
  logic [CW-1:0] cpu_f;
  logic          accept, out_load;

  assign accept = in_valid && in_ready;
  assign cpu_f  = (32'(cpu) >= CPUS) ? '0 : CW'(cpu);
  assign last   = pv && (pidx == SW'(SLOTS - 1));

  pts_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (pv),
    .waddr (pidx),
    .wdata (e_new),
    .raddr (ridx[SW-1:0]),
    .rdata (ram_rdata)
  );

  // Per-entry modify while the sweep passes
  always_comb begin
    e_rd        = valid[pidx] ? entry_t'(ram_rdata) : RESET_ENTRY;
    e_new       = e_rd;
    is_prev     = had_r && (pidx == prev_r);
    is_tgt      = (pidx == tgt_r);
    slot_hit    = (32'(slot_r) == 32'(pidx));
    take_create = 1'b0;
    keep_hit    = 1'b0;
    sl_dec      = (e_rd.sl > 8'd0) ? e_rd.sl - 8'd1 : e_rd.sl;
    if (!phase) begin
      unique case (op_r)
        OP_CREATE: begin
          if (!found && e_rd.st == ST_FREE) begin
            take_create = 1'b1;
            e_new = '{st: ST_READY, af: AFF_ANY, pr: prio_r, sl: reload,
                      wk: 32'd0, fr: 1'b1};
          end
        end
        OP_EXIT: begin
          if (is_prev) e_new.st = ST_FREE;
        end
        OP_SLEEP: begin
          if (is_prev) begin
            e_new.st = ST_SLEEPING;
            e_new.wk = tick_counter + dur_r;
          end
        end
        OP_BLOCK: begin
          if (is_prev) e_new.st = ST_BLOCKED;
        end
        OP_TICK: begin
          if (e_rd.st == ST_SLEEPING && tick_counter >= e_rd.wk) e_new.st = ST_READY;
          if (is_prev) begin
            e_new.sl = sl_dec;
            if (sl_dec > 8'd0 && e_new.st == ST_RUNNING) begin
              keep_hit = 1'b1;
            end else begin
              e_new.st = ST_READY;
            end
          end
        end
        OP_WAKE: begin
          if (slot_hit && e_rd.st == ST_BLOCKED) e_new.st = ST_READY;
        end
        OP_MKRDY: begin
          if (slot_hit) e_new.st = ST_READY;
        end
        OP_LOAD: begin
        end
        default: begin
        end
      endcase
    end else begin
      if (is_tgt) begin
        e_new.st = ST_RUNNING;
        e_new.sl = reload;
        if (disp_r) begin
          e_new.af = AFW'(cpu_r);
          e_new.fr = 1'b0;
        end
      end else if (op_r == OP_TICK && !had_r && e_rd.st == ST_RUNNING) begin
        // demote runners on every CPU before the dispatch
        e_new.st = ST_READY;
      end
    end
    run_new = (e_new.st == ST_READY || e_new.st == ST_RUNNING) &&
              (e_new.af == AFF_ANY || e_new.af == AFW'(cpu_r));
    cnt_hit = (e_rd.st != ST_FREE) && (all_r || e_rd.af == AFW'(cpu_r));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((op_t'(operation) == OP_SLEEP || op_t'(operation) == OP_BLOCK) &&
              !cur_has[cpu_f]) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SWEEP;
          end
        end
      end
      S_SWEEP:  if (last) state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_DONE;
        if (!phase) begin
          priority case (1'b1)
            (op_r == OP_EXIT || op_r == OP_SLEEP || op_r == OP_BLOCK): begin
              if (best_v) state_next = S_SWEEP;
            end
            (op_r == OP_TICK): begin
              if (had_r ? !keep : best_v) state_next = S_SWEEP;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = (state == S_IDLE);
    cfg_ready = 1'b1;
    issue     = (state == S_SWEEP) && (32'(ridx) < SLOTS);
    out_load  = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      reload       <= RELOAD_RESET;
      tick_counter <= 32'd0;
      cur_has      <= '0;
      valid        <= '0;
      pv           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) reload <= slice_reload;

      // sweep pipeline: read one entry, write it back in the following cycle
      pv   <= issue;
      pidx <= ridx[SW-1:0];
      if (issue) ridx <= ridx + RW'(1);
      if (pv) begin
        valid[pidx] <= 1'b1;
        if (take_create) begin
          found <= 1'b1;
          fidx  <= pidx;
        end
        if (keep_hit) keep <= 1'b1;
        if (!phase && run_new && (!best_v || e_new.pr > best_pr)) begin
          best_v   <= 1'b1;
          best_idx <= pidx;
          best_pr  <= e_new.pr;
        end
        if (!phase && op_r == OP_LOAD && cnt_hit) cnt <= cnt + RW'(1);
        if (phase && is_tgt && disp_r) res_fresh <= e_rd.fr;
      end

      if (accept) begin
        op_r       <= op_t'(operation);
        cpu_r      <= cpu_f;
        slot_r     <= slot;
        prio_r     <= PW'(priority_req);
        dur_r      <= duration;
        all_r      <= all_cpus;
        had_r      <= cur_has[cpu_f];
        prev_r     <= cur_slot[cpu_f];
        phase      <= 1'b0;
        ridx       <= '0;
        found      <= 1'b0;
        best_v     <= 1'b0;
        cnt        <= '0;
        keep       <= 1'b0;
        res_slot   <= '0;
        res_sw     <= 1'b0;
        res_fresh  <= 1'b0;
        res_status <= ((op_t'(operation) == OP_SLEEP || op_t'(operation) == OP_BLOCK) &&
                       !cur_has[cpu_f]) ? RES_NO_CURRENT : RES_OK;
        if (op_t'(operation) == OP_TICK) tick_counter <= tick_counter + 32'd1;
      end

      if (state == S_DECIDE && !phase) begin
        phase <= 1'b1;
        ridx  <= '0;
        unique case (op_r)
          OP_CREATE: begin
            res_status <= found ? RES_OK : RES_NO_FREE;
            res_slot   <= found ? fidx : '0;
          end
          OP_EXIT, OP_SLEEP, OP_BLOCK: begin
            if (!best_v) begin
              cur_has[cpu_r] <= 1'b0;
              res_status     <= RES_IDLE;
            end else begin
              tgt_r           <= best_idx;
              disp_r          <= 1'b1;
              res_slot        <= best_idx;
              res_sw          <= !had_r || (best_idx != prev_r);
              cur_has[cpu_r]  <= 1'b1;
              cur_slot[cpu_r] <= best_idx;
            end
          end
          OP_TICK: begin
            if (!had_r) begin
              if (!best_v) begin
                res_status <= RES_IDLE;
              end else begin
                tgt_r           <= best_idx;
                disp_r          <= 1'b1;
                res_slot        <= best_idx;
                res_sw          <= 1'b1;
                cur_has[cpu_r]  <= 1'b1;
                cur_slot[cpu_r] <= best_idx;
              end
            end else if (keep) begin
              // slice left and still running: hold the current slot as is
              res_slot <= prev_r;
            end else if (!best_v || best_idx == prev_r) begin
              // hold the current slot and refill its slice
              res_slot <= prev_r;
              tgt_r    <= prev_r;
              disp_r   <= 1'b0;
            end else begin
              tgt_r           <= best_idx;
              disp_r          <= 1'b1;
              res_slot        <= best_idx;
              res_sw          <= 1'b1;
              cur_slot[cpu_r] <= best_idx;
            end
          end
          OP_WAKE, OP_MKRDY: begin
          end
          OP_LOAD: begin
          end
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid   <= 1'b1;
        status      <= res_status;
        slot_out    <= 4'(res_slot);
        switched    <= res_sw;
        fresh_start <= res_fresh;
        load_count  <= (32'(cnt) > 31) ? 5'd31 : 5'(cnt);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PTS_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state != S_IDLE), "accept left fsm idle")
  `PTS_ASSERT(a_no_free_create, (out_load && res_status == RES_NO_FREE) |-> (op_r == OP_CREATE), "no-free status on non-create")
  `PTS_ASSERT_NEVER(a_sweep_bounds, pv && (32'(pidx) >= SLOTS), "sweep index past table")
  `PTS_ASSERT(a_dispatch_current, (state == S_DECIDE && phase && disp_r) |-> (cur_has[cpu_r] && cur_slot[cpu_r] == tgt_r), "dispatched slot not current")

endmodule

FILE: tb/sv/scheduler_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the priority task scheduler: tracks the slot table from observed beats.
// Depends on pts_pkg for operation, slot state and status codes.
module scheduler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  slice_reload,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [1:0]  cpu,
  input  logic [3:0]  slot,
  input  logic [7:0]  priority_req,
  input  logic [31:0] duration,
  input  logic        all_cpus,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [3:0]  slot_out,
  input  logic        switched,
  input  logic        fresh_start,
  input  logic [4:0]  load_count,
  output int          errors,
  output int          pending
);
  import pts_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NCPU  = CPUS_DEF;
  localparam logic [2:0] AFF_ANY = 3'(NCPU);

  typedef struct {
    res_t       st;
    logic [3:0] slot_id;
    bit         sw;
    bit         fr;
    logic [4:0] cnt;
  } sched_res_t;

  slot_st_t    sst[NSLOT];
  logic [2:0]  aff[NSLOT];
  logic [7:0]  pri[NSLOT];
  logic [7:0]  slc[NSLOT];
  logic [31:0] wake_at[NSLOT];
  bit          fresh[NSLOT];
  bit          has_cur[NCPU];
  int          cur[NCPU];
  logic [31:0] ticks;
  logic [7:0]  reload;
  sched_res_t  expected_results[$];

  assign pending = expected_results.size();

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      sst[i] = ST_FREE;
      aff[i] = AFF_ANY;
      pri[i] = 8'd1;
      slc[i] = RELOAD_RESET;
      wake_at[i] = '0;
      fresh[i] = 0;
    end
    for (int c = 0; c < NCPU; c++) begin
      has_cur[c] = 0;
      cur[c] = 0;
    end
    ticks = '0;
    reload = RELOAD_RESET;
  endfunction

  // Highest priority runnable slot for this CPU; lowest index on a tie.
  function automatic int best_slot(int c);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if ((sst[i] == ST_READY || sst[i] == ST_RUNNING) &&
          (aff[i] == AFF_ANY || aff[i] == 3'(c)))
        if (best < 0 || pri[i] > pri[best]) best = i;
    return best;
  endfunction

  function automatic bit run_on(int c, int n);
    bit was_fresh;
    was_fresh = fresh[n];
    has_cur[c] = 1;
    cur[c] = n;
    sst[n] = ST_RUNNING;
    slc[n] = reload;
    aff[n] = 3'(c);
    fresh[n] = 0;
    return was_fresh;
  endfunction

  function automatic void resched(int c, bit had, int prev, ref sched_res_t r);
    int nx;
    if (has_cur[c] && sst[cur[c]] == ST_RUNNING) sst[cur[c]] = ST_READY;
    has_cur[c] = 0;
    nx = best_slot(c);
    if (nx < 0) begin
      r.st = RES_IDLE;
      return;
    end
    r.fr = run_on(c, nx);
    r.st = RES_OK;
    r.slot_id = 4'(nx);
    r.sw = !had || nx != prev;
  endfunction

  function automatic void tick_cpu(int c, ref sched_res_t r);
    int nx;
    int cp;
    ticks++;
    for (int i = 0; i < NSLOT; i++)
      if (sst[i] == ST_SLEEPING && ticks >= wake_at[i]) sst[i] = ST_READY;
    if (!has_cur[c]) begin
      nx = best_slot(c);
      if (nx < 0) begin
        r.st = RES_IDLE;
        return;
      end
      // demote every running slot, other CPUs included
      for (int i = 0; i < NSLOT; i++)
        if (sst[i] == ST_RUNNING) sst[i] = ST_READY;
      r.fr = run_on(c, nx);
      r.slot_id = 4'(nx);
      r.sw = 1;
      return;
    end
    cp = cur[c];
    r.slot_id = 4'(cp);
    if (slc[cp] > 0) slc[cp]--;
    if (slc[cp] > 0 && sst[cp] == ST_RUNNING) return;
    sst[cp] = ST_READY;
    nx = best_slot(c);
    if (nx < 0 || nx == cp) begin
      sst[cp] = ST_RUNNING;
      slc[cp] = reload;
      return;
    end
    r.fr = run_on(c, nx);
    r.slot_id = 4'(nx);
    r.sw = 1;
  endfunction

  function automatic sched_res_t apply_op(op_t op, int c, int s, logic [7:0] p,
                                          logic [31:0] dur, bit all);
    sched_res_t r;
    bit had;
    int prev;
    int n;
    r = '{RES_OK, 4'd0, 0, 0, 5'd0};
    had = has_cur[c];
    prev = cur[c];
    case (op)
      OP_CREATE: begin
        n = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
          if (sst[i] == ST_FREE) n = i;
        if (n < 0) r.st = RES_NO_FREE;
        else begin
          sst[n] = ST_READY;
          fresh[n] = 1;
          aff[n] = AFF_ANY;
          pri[n] = p;
          slc[n] = reload;
          wake_at[n] = '0;
          r.slot_id = 4'(n);
        end
      end
      OP_EXIT: begin
        if (had) begin
          sst[prev] = ST_FREE;
          has_cur[c] = 0;
        end
        resched(c, had, prev, r);
      end
      OP_TICK: tick_cpu(c, r);
      OP_SLEEP, OP_BLOCK: begin
        if (!had) r.st = RES_NO_CURRENT;
        else begin
          if (op == OP_SLEEP) begin
            wake_at[prev] = ticks + dur;
            sst[prev] = ST_SLEEPING;
          end else begin
            sst[prev] = ST_BLOCKED;
          end
          resched(c, had, prev, r);
        end
      end
      OP_WAKE: if (sst[s] == ST_BLOCKED) sst[s] = ST_READY;
      OP_MKRDY: sst[s] = ST_READY;
      default: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++)
          if (sst[i] != ST_FREE && (all || aff[i] == 3'(c))) n++;
        r.cnt = 5'(n > 31 ? 31 : n);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sched_res_t want;
    if (rst) begin
      clear_table();
      expected_results.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) reload = slice_reload;
      if (in_valid && in_ready)
        expected_results.push_back(apply_op(op_t'(operation), int'(cpu), int'(slot),
                                            priority_req, duration, all_cpus));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d slot=%0d", $time,
                   status, slot_out);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st || slot_out !== want.slot_id || switched !== want.sw ||
              fresh_start !== want.fr || load_count !== want.cnt) begin
            $display("%0t: mismatch expected st=%0d slot=%0d sw=%0d fr=%0d cnt=%0d",
                     $time, want.st, want.slot_id, want.sw, want.fr, want.cnt);
            $display("%0t:          actual   st=%0d slot=%0d sw=%0d fr=%0d cnt=%0d",
                     $time, status, slot_out, switched, fresh_start, load_count);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, stimulus phases and verdict.
// Depends on pts_pkg, priority_task_scheduler_core and scheduler_checker.
module testbench;
  import pts_pkg::*;

  localparam int RANDOM_PER_PHASE = 430;
  localparam int DRAIN_CYCLES     = 80;   // extra wait after the last result drains
  localparam int CYCLE_LIMIT      = 1000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  slice_reload = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [1:0]  cpu = '0;
  logic [3:0]  slot = '0;
  logic [7:0]  priority_req = '0;
  logic [31:0] duration = '0;
  logic        all_cpus = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic        switched;
  logic        fresh_start;
  logic [4:0]  load_count;

  int errors;
  int pending;
  int cycles = 0;
  int idle_pct = 0;    // chance per cycle that the sender holds off
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  logic hold = 0;      // long receiver hold-off
  bit   pressure_go = 0;

  priority_task_scheduler_core u_top (.*);

  scheduler_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Bound the run; a hang anywhere ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stall at random, and always while hold is up.
  always @(posedge clk)
    out_ready <= !rst && !hold && ($urandom_range(99) >= stall_pct);

  // Hold off the receiver long enough that the block fills and stalls its
  // input while the sender keeps offering beats.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold <= 1;
    repeat (400) @(posedge clk);
    hold <= 0;
  end

  // Offer one beat; leave valid high so the next beat can follow back to back.
  task automatic send_op(op_t op, logic [1:0] c, logic [3:0] s, logic [7:0] p,
                         logic [31:0] dur, logic all);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1;
    operation    <= op;
    cpu          <= c;
    slot         <= s;
    priority_req <= p;
    duration     <= dur;
    all_cpus     <= all;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reload(logic [7:0] v);
    cfg_valid    <= 1;
    slice_reload <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // Mostly well-formed traffic: creates, ticks and state changes on a
  // populated table, with small sleeps so sleepers wake within the run.
  task automatic send_random();
    int w;
    op_t op;
    logic [7:0] p;
    logic [31:0] dur;
    w = $urandom_range(99);
    if (w < 14)      op = OP_CREATE;
    else if (w < 44) op = OP_TICK;
    else if (w < 54) op = OP_SLEEP;
    else if (w < 62) op = OP_BLOCK;
    else if (w < 74) op = OP_WAKE;
    else if (w < 81) op = OP_MKRDY;
    else if (w < 91) op = OP_EXIT;
    else             op = OP_LOAD;
    p   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4, 1));
    dur = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(6));
    send_op(op, 2'($urandom), 4'($urandom), p, dur, 1'($urandom));
  endtask

  task automatic random_phase(int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (stall == 61 && i == 20) pressure_go = 1;
      send_random();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reload(8'd255);

    // Directed: empty table, missing current slot, field extremes,
    // make-ready on a free slot, sleeper wake-up, wake and full table.
    send_op(OP_LOAD,  2'd0, 4'd0,  8'd0,   32'd0,          1'b1);
    send_op(OP_TICK,  2'd3, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_SLEEP, 2'd1, 4'd0,  8'd0,   32'hFFFF_FFFF,  1'b0);
    send_op(OP_BLOCK, 2'd2, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_EXIT,  2'd0, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_CREATE, 2'd0, 4'd0, 8'd0,   32'd0,          1'b0);
    send_op(OP_CREATE, 2'd1, 4'd0, 8'd255, 32'd0,          1'b0);
    send_op(OP_MKRDY, 2'd0, 4'd15, 8'd0,   32'd0,          1'b0);
    send_op(OP_WAKE,  2'd0, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_TICK,  2'd2, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_TICK,  2'd0, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_SLEEP, 2'd2, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_TICK,  2'd1, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_BLOCK, 2'd1, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_WAKE,  2'd0, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_EXIT,  2'd1, 4'd0,  8'd0,   32'd0,          1'b0);
    for (int i = 0; i < 6; i++)
      send_op(OP_CREATE, 2'd3, 4'd0, 8'(i * 40), 32'd0, 1'b0);
    for (int i = 0; i < 13; i++)
      send_op(OP_CREATE, 2'd0, 4'd0, 8'd1, 32'd0, 1'b0);
    send_op(OP_LOAD,  2'd2, 4'd0,  8'd0,   32'd0,          1'b0);
    send_op(OP_LOAD,  2'd3, 4'd0,  8'd0,   32'd0,          1'b1);
    drain();

    random_phase(0, 0);
    write_reload(8'd1);
    random_phase(61, 0);
    write_reload(8'd0);   // running slot is rescheduled on every tick
    random_phase(0, 61);
    write_reload(8'($urandom_range(254, 2)));
    random_phase(10, 10);

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
